>>> rtl/n2a_pkg.sv
// shared types, codes and character helpers for the number to ascii formatter
// no dependencies; used by the interfaces, the bcd converter and the top level
package n2a_pkg;

   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int DCNT_W     = 4;
   localparam int BITCNT_W   = 5;

   // format selector codes
   localparam logic [1:0] FMT_DEC  = 2'd0;
   localparam logic [1:0] FMT_HEX  = 2'd1;
   localparam logic [1:0] FMT_TEMP = 2'd2;

   // character constants
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h37;  // 'A' - 10
   localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_UPC   = 8'h43;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

   // digit counts: minimums kept by leading zero removal, hex digits, all bcd digits
   localparam logic [DCNT_W-1:0] DEC_MIN_DIGITS  = 4'd1;
   localparam logic [DCNT_W-1:0] TEMP_MIN_DIGITS = 4'd3;
   localparam logic [DCNT_W-1:0] HEX_DIGITS      = 4'd8;
   localparam logic [DCNT_W-1:0] ALL_DIGITS      = 4'd10;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_CONV  = 8'b0000_0010,
      S_STRIP = 8'b0000_0100,
      S_PRE0  = 8'b0000_1000,
      S_PRE1  = 8'b0001_0000,
      S_DIG   = 8'b0010_0000,
      S_DOT   = 8'b0100_0000,
      S_TAIL  = 8'b1000_0000
   } state_type;

   // "0123456789ABCDEF" lookup
   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] ext;
      ext = {4'h0, nib};
      return (nib < 4'd10) ? (CH_ZERO + ext) : (CH_ALPHA + ext);
   endfunction

   // " C\r\n"
   function automatic logic [CHAR_W-1:0] tail_char(input logic [1:0] idx);
      logic [CHAR_W-1:0] ch;
      unique case (idx)
         2'd0: ch = CH_SPACE;
         2'd1: ch = CH_UPC;
         2'd2: ch = CH_CR;
         2'd3: ch = CH_LF;
         default: ch = CH_SPACE;
      endcase
      return ch;
   endfunction

   // add 3 to every bcd digit that is 5 or more, ahead of the shift
   function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
      logic [BCD_W-1:0] res;
      res = bcd;
      for (int d = 0; d < BCD_DIGITS; d++) begin
         if (bcd[4*d +: 4] >= 4'd5) begin
            res[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
         end
      end
      return res;
   endfunction

endpackage

>>> rtl/n2a_if.sv
// valid/ready channel interfaces for the request and response sides
// depends on n2a_pkg for field widths
interface n2a_req_if
   import n2a_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [1:0]                req_type;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface n2a_rsp_if
   import n2a_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> rtl/n2a_bcd_conv.sv
// bit-serial binary to bcd converter (shift and add 3), one bit per cycle
// depends on n2a_pkg; instantiated by number_to_ascii_formatter_unit
module n2a_bcd_conv
   import n2a_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [VALUE_W-1:0]  mag,
   output logic                done,
   output logic [BCD_W-1:0]    bcd
);

   logic [VALUE_W-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic [BITCNT_W-1:0] cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [BCD_W-1:0]    adj;

   assign adj = bcd_adjust(bcd_ff);

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in = mag;
         bcd_in = '0;
         cnt_in = BITCNT_W'(VALUE_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

>>> rtl/number_to_ascii_formatter_unit.sv
// number to ascii formatter top level: sequencer, leading zero removal, output register
// depends on n2a_pkg, n2a_req_if / n2a_rsp_if and n2a_bcd_conv
//
// Formats one 32-bit value per request as ASCII text, one character per response
// beat with last set on the final character. Selector 0 gives signed decimal,
// 1 gives "0x" and eight uppercase hex digits, 2 reads the value as hundredths
// and gives "[-]int.ff C\r\n"; selector 3 is accepted and produces nothing.
// One request is handled at a time. Decimal and temperature requests start the
// bit-serial bcd converter (one bit per cycle over 32 bits), then drop leading
// zeros (up to nine for decimal, seven for temperature) and emit one character
// per cycle while the response sink takes them. Hex requests skip the converter
// and leading zero removal. The request side is ready again in the same cycle
// that the last character enters the output register; a stalled response sink
// holds the sequencer.
module number_to_ascii_formatter_unit
   import n2a_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   n2a_req_if.sink    req_bus,
   n2a_rsp_if.source  rsp_bus
);

   state_type           state_ff, state_in;
   logic [1:0]          fmt_ff, fmt_in;
   logic                neg_ff, neg_in;
   logic [BCD_W-1:0]    sr_ff, sr_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [1:0]          tcnt_ff, tcnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                adv;
   logic                conv_start;
   logic                conv_done;
   logic [VALUE_W-1:0]  raw;
   logic [VALUE_W-1:0]  mag;
   logic [BCD_W-1:0]    conv_bcd;
   logic [DCNT_W-1:0]   min_digits;
   logic                is_temp;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign raw           = req_bus.value;
   assign mag           = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
   assign is_temp       = (fmt_ff == FMT_TEMP);
   assign min_digits    = is_temp ? TEMP_MIN_DIGITS : DEC_MIN_DIGITS;
   assign conv_start    = accept && (req_bus.req_type == FMT_DEC ||
                                     req_bus.req_type == FMT_TEMP);

   n2a_bcd_conv u_conv (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .mag   (mag),
      .done  (conv_done),
      .bcd   (conv_bcd)
   );

   always_comb begin
      state_in     = state_ff;
      fmt_in       = fmt_ff;
      neg_in       = neg_ff;
      sr_in        = sr_ff;
      dcnt_in      = dcnt_ff;
      tcnt_in      = tcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fmt_in = req_bus.req_type;
               neg_in = raw[VALUE_W-1];
               priority if (req_bus.req_type == FMT_HEX) begin
                  sr_in    = {raw, 8'h00};
                  dcnt_in  = HEX_DIGITS;
                  state_in = S_PRE0;
               end else if (conv_start) begin
                  state_in = S_CONV;
               end else begin
                  state_in = S_IDLE;  // unused selector, dropped
               end
            end
         end
         S_CONV: begin
            if (conv_done) begin
               sr_in    = conv_bcd;
               dcnt_in  = ALL_DIGITS;
               state_in = S_STRIP;
            end
         end
         S_STRIP: begin
            if (dcnt_ff > min_digits && sr_ff[BCD_W-1 -: 4] == 4'h0) begin
               sr_in   = {sr_ff[BCD_W-5:0], 4'h0};
               dcnt_in = dcnt_ff - 1'b1;
            end else begin
               state_in = neg_ff ? S_PRE0 : S_DIG;
            end
         end
         S_PRE0: begin
            if (adv) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_char_in  = (fmt_ff == FMT_HEX) ? CH_ZERO : CH_MINUS;
               state_in     = (fmt_ff == FMT_HEX) ? S_PRE1 : S_DIG;
            end
         end
         S_PRE1: begin
            if (adv) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_char_in  = CH_X;
               state_in     = S_DIG;
            end
         end
         S_DIG: begin
            if (adv) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = hex_char(sr_ff[BCD_W-1 -: 4]);
               rsp_last_in  = (dcnt_ff == 4'd1) && !is_temp;
               sr_in        = {sr_ff[BCD_W-5:0], 4'h0};
               dcnt_in      = dcnt_ff - 1'b1;
               priority if (dcnt_ff == 4'd1) begin
                  tcnt_in  = 2'd0;
                  state_in = is_temp ? S_TAIL : S_IDLE;
               end else if (is_temp && dcnt_ff == 4'd3) begin
                  state_in = S_DOT;  // integer part done, fraction follows
               end else begin
                  state_in = S_DIG;
               end
            end
         end
         S_DOT: begin
            if (adv) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_char_in  = CH_DOT;
               state_in     = S_DIG;
            end
         end
         S_TAIL: begin
            if (adv) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = tail_char(tcnt_ff);
               rsp_last_in  = (tcnt_ff == 2'd3);
               tcnt_in      = tcnt_ff + 1'b1;
               if (tcnt_ff == 2'd3) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fmt_ff      <= fmt_in;
      neg_ff      <= neg_in;
      sr_ff       <= sr_in;
      dcnt_ff     <= dcnt_in;
      tcnt_ff     <= tcnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.char_code = rsp_char_ff;
   assign rsp_bus.last      = rsp_last_ff;

endmodule
